@@ design/flpte_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package flpte_pkg;

  localparam int TABLE_PAGES = 64;
  localparam int ENTRIES     = 512;
  localparam int IDX_W       = 9;
  localparam int PAGE_W      = $clog2(TABLE_PAGES);
  localparam int ADDR_W      = PAGE_W + IDX_W;
  localparam int FREE_W      = $clog2(TABLE_PAGES + 1);

  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_MAP       = 2'd1;
  localparam logic [1:0] OP_UNMAP     = 2'd2;

  localparam logic [11:0] TBL_FLAGS = 12'h007;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [63:0]       wdata;
  } mem_req_t;

  typedef struct packed {
    logic [63:0] phys;
    logic [11:0] flags;
    logic        found;
    logic        oot;
  } res_t;

endpackage
`default_nettype wire

@@ design/flpte_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
module flpte_store
  import flpte_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mem_req_t req_i,
  output logic [63:0]   rdata_o,
  output logic          busy_o
);

  logic [63:0]       mem [TABLE_PAGES*ENTRIES];
  logic [63:0]       rdata_q;
  logic              clearing_q, clearing_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [63:0]       wr_data;

  always_comb begin
    clearing_d = clearing_q;
    clr_addr_d = clr_addr_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == {ADDR_W{1'b1}}) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // sweep zeros through the array after reset, then serve the walker
  assign wr_en   = clearing_q | req_i.wr;
  assign wr_addr = clearing_q ? clr_addr_q : req_i.addr;
  assign wr_data = clearing_q ? 64'd0 : req_i.wdata;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req_i.rd && !clearing_q) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clearing_q;

endmodule
`default_nettype wire

@@ design/flpte_walk.sv @@
`timescale 1ns / 1ps
`default_nettype none
module flpte_walk
  import flpte_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [47:0] va_i,
  input  wire logic [63:0] leaf_i,
  output logic             idle_o,
  output mem_req_t         mem_req_o,
  input  wire logic [63:0] mem_rdata_i,
  output logic             res_valid_o,
  output res_t             res_o,
  input  wire logic        res_ack_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [1:0]        op_q, op_d;
  logic [35:0]       vpn_q, vpn_d;
  logic [63:0]       leaf_q, leaf_d;
  logic [1:0]        lvl_q, lvl_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [FREE_W-1:0] free_q, free_d;
  res_t              res_q, res_d;

  logic              present;
  logic [PAGE_W-1:0] next_page;
  logic [1:0]        missing;
  logic [FREE_W+1:0] need;

  function automatic logic [IDX_W-1:0] lvl_idx(input logic [35:0] vpn, input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0:    idx = vpn[35:27];
      2'd1:    idx = vpn[26:18];
      2'd2:    idx = vpn[17:9];
      default: idx = vpn[8:0];
    endcase
    return idx;
  endfunction

  assign present   = mem_rdata_i[0] && (mem_rdata_i[63:12] < 52'(TABLE_PAGES));
  assign next_page = mem_rdata_i[PAGE_W+11:12];
  assign missing   = 2'd3 - lvl_q;
  assign need      = {2'b00, free_q} + (FREE_W+2)'(missing);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    vpn_d     = vpn_q;
    leaf_d    = leaf_q;
    lvl_d     = lvl_q;
    page_d    = page_q;
    free_d    = free_q;
    res_d     = res_q;
    mem_req_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d   = opcode_i;
          vpn_d  = va_i[47:12];
          leaf_d = leaf_i;
          lvl_d  = 2'd0;
          page_d = '0;
          res_d  = '0;
          if (opcode_i inside {OP_TRANSLATE, OP_MAP, OP_UNMAP}) begin
            mem_req_o.rd   = 1'b1;
            mem_req_o.addr = {{PAGE_W{1'b0}}, va_i[47:39]};
            state_d        = ST_READ;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      ST_READ: begin
        if (lvl_q == 2'd3) begin
          // leaf entry: translate or unmap only
          if (mem_rdata_i[0]) begin
            res_d.found = 1'b1;
            res_d.phys  = {mem_rdata_i[63:12], 12'd0};
            if (op_q == OP_TRANSLATE) begin
              res_d.flags = mem_rdata_i[11:0];
            end else begin
              mem_req_o.wr   = 1'b1;
              mem_req_o.addr = {page_q, lvl_idx(vpn_q, 2'd3)};
            end
          end
          state_d = ST_DONE;
        end else if (present) begin
          page_d = next_page;
          lvl_d  = lvl_q + 2'd1;
          if (op_q == OP_MAP && lvl_q == 2'd2) begin
            state_d = ST_WRITE;
          end else begin
            mem_req_o.rd   = 1'b1;
            mem_req_o.addr = {next_page, lvl_idx(vpn_q, lvl_q + 2'd1)};
          end
        end else if (op_q == OP_MAP) begin
          if (need > (FREE_W+2)'(TABLE_PAGES)) begin
            res_d.oot = 1'b1;
            state_d   = ST_DONE;
          end else begin
            state_d = ST_WRITE;
          end
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_WRITE: begin
        // link fresh tables one level a cycle, then write the leaf
        mem_req_o.wr   = 1'b1;
        mem_req_o.addr = {page_q, lvl_idx(vpn_q, lvl_q)};
        if (lvl_q == 2'd3) begin
          mem_req_o.wdata = leaf_q;
          state_d         = ST_DONE;
        end else begin
          mem_req_o.wdata = {{(52-FREE_W){1'b0}}, free_q, TBL_FLAGS};
          page_d          = free_q[PAGE_W-1:0];
          free_d          = free_q + 1'b1;
          lvl_d           = lvl_q + 2'd1;
        end
      end

      default: begin
        if (res_ack_i) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      free_q  <= FREE_W'(1);
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    vpn_q  <= vpn_d;
    leaf_q <= leaf_d;
    lvl_q  <= lvl_d;
    page_q <= page_d;
    res_q  <= res_d;
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

endmodule
`default_nettype wire

@@ design/four_level_page_table_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake                 Payload
// request   in         in_valid_i / in_stall_o   opcode, virtual_address, map_address, map_flags
// result    out        out_valid_o / out_stall_i phys_address, entry_flags, found, out_of_tables
//
// One request at a time: the time from accept to result is set by the single port of the
// table store (one dependent read or one write per cycle, up to four reads or four writes).
// The next request is accepted after the result has moved into the output register.
// After reset all TABLE_PAGES*512 store entries are swept to zero; in_stall_o stays high.
// A finished result sits in the output register, so the next request is accepted while
// out_stall_i holds it.
module four_level_page_table_engine
  import flpte_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [47:0] virtual_address_i,
  input  wire logic [63:0] map_address_i,
  input  wire logic [63:0] map_flags_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      phys_address_o,
  output logic [11:0]      entry_flags_o,
  output logic             found_o,
  output logic             out_of_tables_o
);

  mem_req_t    mem_req;
  logic [63:0] mem_rdata;
  logic        store_busy;
  logic        walk_idle;
  logic        start;
  logic        res_valid;
  logic        res_ack;
  res_t        res;

  logic        out_valid_q, out_valid_d;
  res_t        out_q;

  assign in_stall_o = !walk_idle || store_busy;
  assign start      = in_valid_i && !in_stall_o;

  flpte_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata),
    .busy_o  (store_busy)
  );

  flpte_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .opcode_i    (opcode_i),
    .va_i        (virtual_address_i),
    .leaf_i      (map_address_i | map_flags_i),
    .idle_o      (walk_idle),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ack_i   (res_ack)
  );

  // load the output register when it is empty or draining
  assign res_ack = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (res_ack) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign phys_address_o  = out_q.phys;
  assign entry_flags_o   = out_q.flags;
  assign found_o         = out_q.found;
  assign out_of_tables_o = out_q.oot;

endmodule
`default_nettype wire

@@ bench/tb_four_level_page_table_engine.sv @@
`timescale 1ns / 1ps
module tb_four_level_page_table_engine;
  import flpte_pkg::*;

  localparam logic [1:0] OP_NOP      = 2'd3;
  localparam int         CYCLE_LIMIT = 500000;
  localparam int         RANDOM_REQS = 1800;

  typedef struct {
    logic [1:0]  op;
    logic [47:0] va;
    logic [63:0] map_addr;
    logic [63:0] map_flags;
    bit          drain;
  } page_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = '0;
  logic [47:0] virtual_address_i = '0;
  logic [63:0] map_address_i = '0;
  logic [63:0] map_flags_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] phys_address_o;
  logic [11:0] entry_flags_o;
  logic        found_o;
  logic        out_of_tables_o;

  page_req_t   pending_reqs[$];
  page_req_t   offered_req;
  res_t        expected_results[$];
  logic [63:0] shadow_tables [TABLE_PAGES*ENTRIES];
  int unsigned shadow_next_free;
  int          accepted_count = 0;
  int          cycle_count = 0;
  int          mismatch_count = 0;

  four_level_page_table_engine dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .virtual_address_i(virtual_address_i),
    .map_address_i    (map_address_i),
    .map_flags_i      (map_flags_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .phys_address_o   (phys_address_o),
    .entry_flags_o    (entry_flags_o),
    .found_o          (found_o),
    .out_of_tables_o  (out_of_tables_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Walk the shadow table and apply one request; returns the expected result.
  function automatic res_t apply_page_op(input page_req_t req);
    res_t        r;
    logic [8:0]  ix [4];
    logic [63:0] e;
    int unsigned pg;
    int unsigned present;
    int unsigned slot;
    int          lvl;
    bit          walking;
    r = '0;
    for (lvl = 0; lvl < 4; lvl++) ix[lvl] = req.va[47 - 9*lvl -: 9];
    pg = 0;
    present = 0;
    walking = 1'b1;
    for (lvl = 0; lvl < 3; lvl++) begin
      if (walking) begin
        e = shadow_tables[pg*ENTRIES + ix[lvl]];
        // an entry pointing past the store counts as absent
        if (!e[0] || (e >> 12) >= TABLE_PAGES) begin
          walking = 1'b0;
        end else begin
          pg = int'(e >> 12);
          present++;
        end
      end
    end
    case (req.op)
      OP_TRANSLATE, OP_UNMAP: begin
        if (present == 3) begin
          slot = pg*ENTRIES + ix[3];
          e = shadow_tables[slot];
          if (e[0]) begin
            r.found = 1'b1;
            r.phys  = {e[63:12], 12'h000};
            if (req.op == OP_TRANSLATE) r.flags = e[11:0];
            else shadow_tables[slot] = '0;
          end
        end
      end
      OP_MAP: begin
        if (shadow_next_free + (3 - present) > TABLE_PAGES) begin
          r.oot = 1'b1;
        end else begin
          for (lvl = int'(present); lvl < 3; lvl++) begin
            shadow_tables[pg*ENTRIES + ix[lvl]] =
              (64'(shadow_next_free) << 12) | 64'(TBL_FLAGS);
            pg = shadow_next_free;
            shadow_next_free++;
          end
          shadow_tables[pg*ENTRIES + ix[3]] = req.map_addr | req.map_flags;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Phase schedule: sender 30 / receiver 65, then swapped, then no idling.
  function automatic int idle_pct(input bit sender);
    if (accepted_count < 600) return sender ? 30 : 65;
    if (accepted_count < 1200) return sender ? 65 : 30;
    return 0;
  endfunction

  function automatic logic [8:0] hot_index();
    case ($urandom_range(3))
      0: return 9'h000;
      1: return 9'h1FF;
      2: return 9'h0AA;
      default: return 9'h155;
    endcase
  endfunction

  // Few hot indices per level so tables are shared and fill up gradually.
  function automatic logic [47:0] pick_va();
    logic [47:0] va;
    int          lvl;
    va = 48'({$urandom, $urandom});
    for (lvl = 0; lvl < 4; lvl++) begin
      if ($urandom_range(9) >= (lvl == 3 ? 7 : 9)) va[47 - 9*lvl -: 9] = 9'($urandom);
      else va[47 - 9*lvl -: 9] = hot_index();
    end
    return va;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %0d at cycle %0d: %s got %h want %h",
             mismatch_count, cycle_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_req(input logic [1:0] op, input logic [47:0] va,
                         input logic [63:0] ma, input logic [63:0] mf, input bit drain);
    page_req_t req;
    req.op        = op;
    req.va        = va;
    req.map_addr  = ma;
    req.map_flags = mf;
    req.drain     = drain;
    pending_reqs.push_back(req);
  endtask

  // Request driver: hold an offered request until accepted.
  always @(posedge clk_i) begin
    bit fire;
    if (rst_ni) begin
      fire = in_valid_i && !in_stall_o;
      if (fire) begin
        expected_results.push_back(apply_page_op(offered_req));
        accepted_count++;
      end
      if (in_valid_i && !fire) begin
        // hold
      end else if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct(1'b1) &&
                   !(pending_reqs[0].drain && expected_results.size() != 0)) begin
        offered_req = pending_reqs.pop_front();
        in_valid_i        <= 1'b1;
        opcode_i          <= offered_req.op;
        virtual_address_i <= offered_req.va;
        map_address_i     <= offered_req.map_addr;
        map_flags_i       <= offered_req.map_flags;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result stall, with one long hold-off so the block backs up.
  always @(posedge clk_i) begin
    int hold_left;
    bit hold_done;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && accepted_count >= 300) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct(1'b0));
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result phys_address", phys_address_o, '0);
      end else begin
        want = expected_results.pop_front();
        if (phys_address_o !== want.phys)
          report_mismatch("phys_address", phys_address_o, want.phys);
        if (entry_flags_o !== want.flags)
          report_mismatch("entry_flags", 64'(entry_flags_o), 64'(want.flags));
        if (found_o !== want.found)
          report_mismatch("found", 64'(found_o), 64'(want.found));
        if (out_of_tables_o !== want.oot)
          report_mismatch("out_of_tables", 64'(out_of_tables_o), 64'(want.oot));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [47:0] mapped_vas[$];
    logic [47:0] va;
    logic [63:0] ma;
    logic [63:0] mf;
    logic [1:0]  op;
    int          n;
    int          roll;

    foreach (shadow_tables[i]) shadow_tables[i] = '0;
    shadow_next_free = 1;

    // empty table, first map, hit and miss on translate and unmap
    add_req(OP_TRANSLATE, 48'h0, '0, '0, 1'b0);
    add_req(OP_UNMAP, 48'h0, '0, '0, 1'b0);
    add_req(OP_MAP, 48'h0, 64'h0, 64'h1, 1'b0);
    add_req(OP_TRANSLATE, 48'h0, '0, '0, 1'b0);
    add_req(OP_MAP, '1, '1, '1, 1'b0);
    add_req(OP_TRANSLATE, '1, '1, '1, 1'b0);
    add_req(OP_UNMAP, '1, '1, '1, 1'b0);
    add_req(OP_UNMAP, '1, '0, '0, 1'b0);
    add_req(OP_TRANSLATE, '1, '0, '0, 1'b0);
    // leaf written without the present bit reads back as absent
    add_req(OP_MAP, 48'h0000_0000_1FFF, 64'hA5A5_A5A5_A5A5_A000, 64'h0, 1'b0);
    add_req(OP_TRANSLATE, 48'h0000_0000_1000, '0, '0, 1'b0);
    add_req(OP_UNMAP, 48'h0000_0000_1ABC, '0, '0, 1'b0);
    add_req(OP_NOP, '1, '1, '1, 1'b0);
    add_req(OP_MAP, 48'h8000_0000_0FFF, 64'h8000_0000_0000_0000, 64'h0E03, 1'b0);
    add_req(OP_TRANSLATE, 48'h8000_0000_0000, '0, '0, 1'b0);
    add_req(OP_TRANSLATE, 48'h8000_0000_1000, '0, '0, 1'b0);
    add_req(OP_MAP, 48'h8000_0000_0000, 64'h5A5A_5A5A_5A5A_5FFF, 64'hFFFF_0000_0000_0001, 1'b0);
    add_req(OP_UNMAP, 48'h8000_0000_0000, '0, '0, 1'b0);
    add_req(OP_TRANSLATE, 48'h8000_0000_0000, '0, '0, 1'b0);
    add_req(OP_NOP, 48'h0, '0, '0, 1'b0);

    for (n = 0; n < RANDOM_REQS; n++) begin
      roll = $urandom_range(99);
      if (roll < 35) op = OP_MAP;
      else if (roll < 70) op = OP_TRANSLATE;
      else if (roll < 94) op = OP_UNMAP;
      else if (roll < 97) op = OP_NOP;
      else op = 2'($urandom);
      if (mapped_vas.size() > 0 && $urandom_range(9) < (op == OP_MAP ? 3 : 7))
        va = {mapped_vas[$urandom_range(mapped_vas.size() - 1)][47:12], 12'($urandom)};
      else
        va = pick_va();
      ma = {$urandom, $urandom};
      mf = {$urandom, $urandom};
      if (op == OP_MAP) begin
        if ($urandom_range(99) < 85) mf[0] = 1'b1;
        mapped_vas.push_back(va);
        if (mapped_vas.size() > 32) void'(mapped_vas.pop_front());
      end
      add_req(op, va, ma, mf, n == 900 || n == 1500);
    end

    // fresh top-level slots until the allocator runs dry
    for (n = 0; n < 25; n++) begin
      va = {9'(9'h100 + n), 27'($urandom), 12'($urandom)};
      add_req(OP_MAP, va, {$urandom, $urandom}, {$urandom, $urandom} | 64'h1, 1'b0);
      add_req(OP_TRANSLATE, va, '0, '0, 1'b0);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/flpte_pkg.sv
design/flpte_store.sv
design/flpte_walk.sv
design/four_level_page_table_engine.sv
bench/tb_four_level_page_table_engine.sv
